// ----- rtl/core/hjs_pkg.sv -----
// Package for the Halton 2,3 jitter sequencer: payload structs, opcodes,
// register indexes, divider request/response structs and the period table.
// No dependencies.
package hjs_pkg;

  localparam int MAX_PERIOD = 72;
  localparam int X_DEN      = 256;
  localparam int Y_DEN      = 243;
  localparam int DIV_W      = 24;
  localparam int DVD_W      = 30;
  localparam int QUO_W      = 31;
  localparam int STEP_W     = 5;

  typedef enum logic [2:0] {
    OP_PREPARE  = 3'd0,
    OP_COMMIT   = 3'd1,
    OP_CANCEL   = 3'd2,
    OP_HIST_RST = 3'd3,
    OP_IMM_RST  = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_RECON_MODE    = 2'd0,
    CFG_QUALITY_LEVEL = 2'd1,
    CFG_RENDER_WIDTH  = 2'd2,
    CFG_RENDER_HEIGHT = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       new_history;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic        [6:0]  phase;
    logic        [6:0]  period;
    logic signed [31:0] x_offset;
    logic signed [31:0] y_offset;
    logic               starts_new;
    logic               prev_valid;
    logic        [6:0]  prev_phase;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic              init_q;
    logic [DIV_W-1:0]  init_rem;
    logic [DIV_W-1:0]  divisor;
    logic [DVD_W-1:0]  dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_rsp_t;

  function automatic logic [6:0] period_for(input logic [1:0] mode, input logic [2:0] q);
    logic [7:0] p;
    p = 8'd1;
    unique case (mode)
      2'd3: p = 8'd64;
      2'd2: begin
        unique case (q)
          3'd0:    p = 8'd8;
          3'd1:    p = 8'd18;
          3'd2:    p = 8'd24;
          3'd3:    p = 8'd32;
          3'd4:    p = 8'd72;
          default: p = 8'd64;
        endcase
      end
      2'd1: p = 8'd64;
      default: p = 8'd1;
    endcase
    if (p > 8'(MAX_PERIOD)) begin
      p = 8'(MAX_PERIOD);
    end
    return p[6:0];
  endfunction

endpackage

// ----- rtl/core/hjs_divider.sv -----
// Serial restoring divider, one quotient bit per cycle.
// Depends on hjs_pkg (div_req_t, div_rsp_t, widths).
module hjs_divider import hjs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [DVD_W-1:0]  dvd;
  logic [QUO_W-1:0]  quo;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DIV_W:0] trial;
  logic [DIV_W:0] diff;
  logic           ge;

  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (req.start) begin
      rem     <= req.init_rem;
      divisor <= req.divisor;
      dvd     <= req.dividend;
      quo     <= {{(QUO_W-1){1'b0}}, req.init_q};
      cnt     <= req.steps;
      busy    <= 1'b1;
      done    <= 1'b0;
    end else if (busy) begin
      rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      dvd  <= {dvd[DVD_W-2:0], 1'b0};
      quo  <= {quo[QUO_W-2:0], ge};
      cnt  <= cnt - STEP_W'(1);
      busy <= cnt != STEP_W'(1);
      done <= cnt == STEP_W'(1);
    end else begin
      done <= 1'b0;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

// ----- rtl/core/halton_jitter_sequencer_top.sv -----
// Halton 2,3 subpixel jitter sequencer, top level with sequencer and state.
// Depends on hjs_pkg and hjs_divider.
// Prepare: the result is computed with the shared serial divider (7 steps phase modulo, 30
// each for x and y) plus 5 base-3 digit steps. Other opcodes go straight to the output
// state. No new transaction is taken until the result is registered on the output.
// rst (synchronous, active high) clears the sequencer and history state and restores register defaults.
module halton_jitter_sequencer_top import hjs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD_GO, S_MOD_WAIT, S_TERN, S_XSET, S_XGO, S_XWAIT,
    S_YSET, S_YGO, S_YWAIT, S_OUT
  } state_t;

  typedef struct packed {
    logic        [6:0]  phase;
    logic        [6:0]  period;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               starts_new;
    logic               prev_valid;
    logic        [6:0]  prev_phase;
    logic signed [31:0] prev_x;
    logic signed [31:0] prev_y;
  } sample_t;

  state_t state;

  logic [1:0]  recon_mode;
  logic [2:0]  quality_level;
  logic [15:0] render_width;
  logic [15:0] render_height;

  logic [6:0]  next_phase;
  logic        has_prepared;
  sample_t     smp;
  logic [6:0]  committed_phase;
  logic [31:0] committed_x;
  logic [31:0] committed_y;
  logic        committed_valid;
  logic        ok_r;

  logic [6:0]       ph_w;
  logic [6:0]       per_w;
  logic             nh_w;
  logic [6:0]       phase_w;
  logic [6:0]       n_w;
  logic [7:0]       b_w;
  logic [2:0]       tcnt;
  logic [8:0]       mag_w;
  logic             neg_w;
  logic [DIV_W-1:0] dvs_w;
  logic [31:0]      x_w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0] w_size;
  logic [15:0] h_size;
  logic [14:0] tprod;
  logic [6:0]  tq;
  logic [1:0]  tr;
  logic [8:0]  a_two;
  logic [8:0]  b_two;
  logic [7:0]  a_num;
  logic [DIV_W-1:0] mag_ext;
  logic        init_ge;
  logic [31:0] q_signed;
  logic [7:0]  phase_inc;
  logic        accept;

  hjs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;

  assign w_size = (render_width  == 16'd0) ? 16'd1 : render_width;
  assign h_size = (render_height == 16'd0) ? 16'd1 : render_height;

  // base-3 digit: n/3 by reciprocal, exact for n < 128
  assign tprod = 15'(n_w) * 15'd171;
  assign tq    = {1'b0, tprod[14:9]};
  assign tr    = 2'(n_w - 7'(3 * tq));

  assign a_num = {phase_w[0], phase_w[1], phase_w[2], phase_w[3],
                  phase_w[4], phase_w[5], phase_w[6], 1'b0};
  assign a_two = {a_num, 1'b0};
  assign b_two = {b_w, 1'b0};

  assign mag_ext  = DIV_W'(mag_w);
  assign init_ge  = mag_ext >= dvs_w;
  assign q_signed = neg_w ? (32'd0 - {1'b0, div_rsp.quotient}) : {1'b0, div_rsp.quotient};
  assign phase_inc = {1'b0, smp.phase} + 8'd1;

  always_comb begin
    div_req          = '0;
    div_req.divisor  = dvs_w;
    div_req.init_q   = init_ge;
    div_req.init_rem = init_ge ? (mag_ext - dvs_w) : mag_ext;
    div_req.steps    = STEP_W'(DVD_W);
    unique case (state)
      S_MOD_GO: begin
        div_req.start    = 1'b1;
        div_req.divisor  = DIV_W'(per_w);
        div_req.init_q   = 1'b0;
        div_req.init_rem = '0;
        div_req.dividend = {ph_w, {(DVD_W-7){1'b0}}};
        div_req.steps    = STEP_W'(7);
      end
      S_XGO, S_YGO: div_req.start = 1'b1;
      default: div_req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      recon_mode      <= 2'd0;
      quality_level   <= 3'd0;
      render_width    <= 16'd1;
      render_height   <= 16'd1;
      next_phase      <= 7'd0;
      has_prepared    <= 1'b0;
      smp             <= '0;
      committed_phase <= 7'd0;
      committed_x     <= 32'd0;
      committed_y     <= 32'd0;
      committed_valid <= 1'b0;
      ok_r            <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_RECON_MODE:    recon_mode    <= cfg_data[1:0];
          CFG_QUALITY_LEVEL: quality_level <= cfg_data[2:0];
          CFG_RENDER_WIDTH:  render_width  <= cfg_data;
          CFG_RENDER_HEIGHT: render_height <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_data.opcode)
              OP_PREPARE: begin
                ph_w  <= in_data.new_history ? 7'd0 : next_phase;
                per_w <= period_for(recon_mode, quality_level);
                nh_w  <= in_data.new_history;
                ok_r  <= 1'b1;
                state <= S_MOD_GO;
              end
              OP_COMMIT: begin
                ok_r  <= has_prepared;
                state <= S_OUT;
                if (has_prepared) begin
                  committed_phase <= smp.phase;
                  committed_x     <= smp.x;
                  committed_y     <= smp.y;
                  committed_valid <= 1'b1;
                  next_phase      <= (phase_inc >= {1'b0, smp.period}) ? 7'd0
                                                                       : phase_inc[6:0];
                  has_prepared    <= 1'b0;
                end
              end
              OP_CANCEL: begin
                ok_r         <= 1'b1;
                has_prepared <= 1'b0;
                state        <= S_OUT;
              end
              OP_HIST_RST: begin
                ok_r            <= !has_prepared || (smp.phase == 7'd0);
                state           <= S_OUT;
                next_phase      <= 7'd0;
                committed_phase <= 7'd0;
                committed_x     <= 32'd0;
                committed_y     <= 32'd0;
                committed_valid <= 1'b0;
                if (has_prepared) begin
                  smp.prev_valid <= 1'b0;
                  smp.starts_new <= 1'b1;
                  smp.prev_phase <= 7'd0;
                  smp.prev_x     <= 32'sd0;
                  smp.prev_y     <= 32'sd0;
                end
              end
              OP_IMM_RST: begin
                ok_r            <= 1'b1;
                state           <= S_OUT;
                smp             <= '0;
                next_phase      <= 7'd0;
                has_prepared    <= 1'b0;
                committed_phase <= 7'd0;
                committed_x     <= 32'd0;
                committed_y     <= 32'd0;
                committed_valid <= 1'b0;
              end
              default: begin
                ok_r  <= 1'b1;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MOD_GO: state <= S_MOD_WAIT;
        S_MOD_WAIT: begin
          if (div_rsp.done) begin
            phase_w <= div_rsp.remainder[6:0];
            n_w     <= div_rsp.remainder[6:0];
            b_w     <= 8'd0;
            tcnt    <= 3'd0;
            state   <= S_TERN;
          end
        end
        S_TERN: begin
          b_w  <= 8'(10'(b_w) * 10'd3 + 10'(tr));
          n_w  <= tq;
          tcnt <= tcnt + 3'd1;
          if (tcnt == 3'd4) begin
            state <= S_XSET;
          end
        end
        S_XSET: begin
          neg_w <= a_two < 9'(X_DEN);
          mag_w <= (a_two < 9'(X_DEN)) ? (9'(X_DEN) - a_two) : (a_two - 9'(X_DEN));
          dvs_w <= {w_size, 8'd0};
          state <= S_XGO;
        end
        S_XGO: state <= S_XWAIT;
        S_XWAIT: begin
          if (div_rsp.done) begin
            x_w   <= q_signed;
            state <= S_YSET;
          end
        end
        S_YSET: begin
          neg_w <= b_two < 9'(Y_DEN);
          mag_w <= (b_two < 9'(Y_DEN)) ? (9'(Y_DEN) - b_two) : (b_two - 9'(Y_DEN));
          dvs_w <= DIV_W'(h_size) * DIV_W'(Y_DEN);
          state <= S_YGO;
        end
        S_YGO: state <= S_YWAIT;
        S_YWAIT: begin
          if (div_rsp.done) begin
            smp.phase      <= phase_w;
            smp.period     <= per_w;
            smp.x          <= x_w;
            smp.y          <= q_signed;
            smp.starts_new <= nh_w;
            smp.prev_valid <= committed_valid && !nh_w;
            smp.prev_phase <= (committed_valid && !nh_w) ? committed_phase : 7'd0;
            smp.prev_x     <= (committed_valid && !nh_w) ? committed_x : 32'd0;
            smp.prev_y     <= (committed_valid && !nh_w) ? committed_y : 32'd0;
            has_prepared   <= 1'b1;
            state          <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_data.ok         <= ok_r;
            out_data.phase      <= smp.phase;
            out_data.period     <= smp.period;
            out_data.x_offset   <= smp.x;
            out_data.y_offset   <= smp.y;
            out_data.starts_new <= smp.starts_new;
            out_data.prev_valid <= smp.prev_valid;
            out_data.prev_phase <= smp.prev_phase;
            out_data.prev_x     <= smp.prev_x;
            out_data.prev_y     <= smp.prev_y;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
